// File: hdl/k_transaction_max_profit_defines.svh
// Assertion macros shared by the k-transaction profit block.
`ifndef K_TRANSACTION_MAX_PROFIT_DEFINES_SVH
`define K_TRANSACTION_MAX_PROFIT_DEFINES_SVH

`ifndef SYNTHESIS
// Concurrent check on the rising clock, switched off while reset is low.
`define KTMP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Concurrent check on the rising clock that also holds during reset.
`define KTMP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define KTMP_ASSERT(lbl, clk, rst_n, prop, msg)
`define KTMP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: hdl/ktmp_pkg.sv
// Package with shared constants and types of the k-transaction profit block.
`timescale 1ns / 1ps
`default_nettype none

package ktmp_pkg;

  // Default sizes of the block.
  localparam int unsigned MAX_TRANS_DEF = 64;
  localparam int unsigned MAX_DAYS_DEF  = 1024;

  // Field and value widths.
  localparam int unsigned PRICE_W  = 16;
  localparam int unsigned PROFIT_W = 31;
  localparam int unsigned VAL_W    = 34;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned OUT_W    = 32;

  // Transaction limit after reset.
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd2;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch a new price and update the running sums
    logic rd_en;   // read one buy/sell entry pair
    logic finish;  // emit the profit and clear the sequence state
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;  // the output register can take a result this cycle
  } status_t;

endpackage

`default_nettype wire

// File: hdl/ktmp_dpath.sv
// Datapath: entry memory, buy/sell update, running rise sum and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "k_transaction_max_profit_defines.svh"

module ktmp_dpath #(
  parameter int unsigned MAX_TRANS = ktmp_pkg::MAX_TRANS_DEF,
  parameter int unsigned MAX_DAYS  = ktmp_pkg::MAX_DAYS_DEF,
  localparam int unsigned KW = $clog2(MAX_TRANS + 1),
  localparam int unsigned AW = (MAX_TRANS > 1) ? $clog2(MAX_TRANS) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ktmp_pkg::cmd_t                cmd_i,
  output      ktmp_pkg::status_t             status_o,
  input  wire logic [KW-1:0]                 k_i,
  input  wire logic [AW-1:0]                 rd_addr_i,
  input  wire logic [ktmp_pkg::PRICE_W-1:0]  price_i,
  input  wire logic                          out_ready_i,
  output      logic                          out_valid_o,
  output      logic [ktmp_pkg::PROFIT_W-1:0] profit_o
);
  import ktmp_pkg::*;

  localparam int unsigned DW = $clog2(MAX_DAYS + 1);
  localparam logic signed [VAL_W-1:0] BUY_RESET = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [PROFIT_W-1:0] PROFIT_MAX = {PROFIT_W{1'b1}};

  // Entry memory: buy value in the upper half, sell value in the lower half.
  logic [2*VAL_W-1:0] mem_q [MAX_TRANS];
  logic [MAX_TRANS-1:0] valid_q;

  logic [2*VAL_W-1:0] rd_data_q;
  logic               rd_valid_q;
  logic               upd_q;
  logic [AW-1:0]      wr_addr_q;

  logic [PRICE_W-1:0]      price_q;
  logic [PRICE_W-1:0]      prev_q;
  logic [SUM_W-1:0]        rise_q;
  logic [DW-1:0]           day_q;
  logic signed [VAL_W-1:0] carry_q;
  logic                    out_valid_q;
  logic [PROFIT_W-1:0]     profit_q;

  logic signed [VAL_W-1:0] price_s;
  logic signed [VAL_W-1:0] buy_old;
  logic signed [VAL_W-1:0] sell_old;
  logic signed [VAL_W-1:0] buy_cand;
  logic signed [VAL_W-1:0] sell_via_buy;
  logic signed [VAL_W-1:0] sell_cand;
  logic signed [VAL_W-1:0] buy_new;
  logic signed [VAL_W-1:0] sell_new;
  logic                    take_buy;
  logic [SUM_W:0]          rise_sum_wide;
  logic [SUM_W-1:0]        rise_d;
  logic [PROFIT_W-1:0]     profit_d;
  logic                    slot_free;

  // Memory write of the updated pair and registered read of the next one.
  always_ff @(posedge clk_i) begin
    if (upd_q) begin
      mem_q[wr_addr_q] <= {buy_new, sell_new};
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Entry valid bits; an entry that is not valid reads as its reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      upd_q      <= 1'b0;
    end else begin
      upd_q <= cmd_i.rd_en;
      if (cmd_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
      if (cmd_i.finish) begin
        valid_q <= '0;
      end else if (upd_q) begin
        valid_q[wr_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      wr_addr_q <= rd_addr_i;
    end
  end

  // One buy/sell update; the carry holds the sell value of the entry below.
  always_comb begin
    price_s      = signed'({{(VAL_W-PRICE_W){1'b0}}, price_q});
    buy_old      = rd_valid_q ? signed'(rd_data_q[2*VAL_W-1:VAL_W]) : BUY_RESET;
    sell_old     = rd_valid_q ? signed'(rd_data_q[VAL_W-1:0]) : '0;
    buy_cand     = carry_q - price_s;
    sell_via_buy = buy_old + price_s;
    take_buy     = buy_cand > buy_old;
    buy_new      = take_buy ? buy_cand : buy_old;
    sell_cand    = take_buy ? carry_q : sell_via_buy;
    sell_new     = (sell_cand > sell_old) ? sell_cand : sell_old;
  end

  // Price and carry registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      price_q <= price_i;
      carry_q <= '0;
    end else if (upd_q) begin
      carry_q <= sell_new;
    end
  end

  // Saturating sum of rises over the previous price.
  always_comb begin
    rise_sum_wide = {1'b0, rise_q} + {{(SUM_W+1-PRICE_W){1'b0}}, price_i - prev_q};
    rise_d        = rise_q;
    if ((day_q != '0) && (price_i > prev_q)) begin
      rise_d = rise_sum_wide[SUM_W] ? {SUM_W{1'b1}} : rise_sum_wide[SUM_W-1:0];
    end
  end

  // Per-sequence running state, cleared when the result is loaded into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      rise_q <= '0;
      day_q  <= '0;
    end else if (cmd_i.finish) begin
      prev_q <= '0;
      rise_q <= '0;
      day_q  <= '0;
    end else if (cmd_i.load) begin
      prev_q <= price_i;
      rise_q <= rise_d;
      if (day_q != DW'(MAX_DAYS)) begin
        day_q <= day_q + 1'b1;
      end
    end
  end

  // Final choice: zero below two days, else the rise sum or the best value after the k-th sell.
  always_comb begin
    if (day_q < DW'(2)) begin
      profit_d = '0;
    end else if (32'(k_i) >= 32'(day_q)) begin
      profit_d = rise_q[SUM_W-1] ? PROFIT_MAX : rise_q[PROFIT_W-1:0];
    end else if (carry_q[VAL_W-1]) begin
      profit_d = '0;
    end else if (|carry_q[VAL_W-2:PROFIT_W]) begin
      profit_d = PROFIT_MAX;
    end else begin
      profit_d = carry_q[PROFIT_W-1:0];
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;

  // Output register; it frees as soon as the receiver takes the transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      profit_q <= profit_d;
    end
  end

  assign status_o.slot_free = slot_free;
  assign out_valid_o        = out_valid_q;
  assign profit_o           = profit_q;

  // The controller only finishes into a free output register.
  `KTMP_ASSERT(a_finish_slot, clk_i, rst_ni, cmd_i.finish |-> slot_free, "finish while output full")
  // Finishing a sequence leaves every entry at its reset value.
  `KTMP_ASSERT(a_finish_clear, clk_i, rst_ni, cmd_i.finish |=> (valid_q == '0), "entries not cleared")
  // The best value after a sell never drops below zero.
  `KTMP_ASSERT(a_carry_pos, clk_i, rst_ni, upd_q |=> !carry_q[VAL_W-1], "negative sell value")

endmodule

`default_nettype wire

// File: hdl/ktmp_ctrl.sv
// Controller: configuration register, item sequencing and entry walk.
`timescale 1ns / 1ps
`default_nettype none
`include "k_transaction_max_profit_defines.svh"

module ktmp_ctrl #(
  parameter int unsigned MAX_TRANS = ktmp_pkg::MAX_TRANS_DEF,
  localparam int unsigned KW = $clog2(MAX_TRANS + 1),
  localparam int unsigned AW = (MAX_TRANS > 1) ? $clog2(MAX_TRANS) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output      logic                        cfg_ready_o,
  input  wire logic [ktmp_pkg::CFG_W-1:0]  cfg_data_i,
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire logic                        in_last_i,
  output      ktmp_pkg::cmd_t              cmd_o,
  input  wire ktmp_pkg::status_t           status_i,
  output      logic [KW-1:0]               k_o,
  output      logic [AW-1:0]               rd_addr_o
);
  import ktmp_pkg::*;

  state_e           state_q, state_d;
  logic [CFG_W-1:0] cfg_q;
  logic [KW-1:0]    k_q, k_d, k_clamp;
  logic             last_q, last_d;
  logic [AW-1:0]    cnt_q, cnt_d;
  logic             run_end;
  cmd_t             cmd;

  // Transaction limit register; writes are always taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign k_clamp = (32'(cfg_q) > 32'(MAX_TRANS)) ? KW'(MAX_TRANS) : KW'(cfg_q);
  assign run_end = (KW'(cnt_q) == (k_q - 1'b1));

  // State and item registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      last_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      last_q  <= last_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    last_d     = last_q;
    cnt_d      = cnt_q;
    cmd        = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.load = 1'b1;
          k_d      = k_clamp;
          last_d   = in_last_i;
          cnt_d    = '0;
          if (k_clamp != '0) begin
            state_d = ST_RUN;
          end else if (in_last_i) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_RUN: begin
        cmd.rd_en = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (run_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = last_q ? ST_FINISH : ST_IDLE;
      end
      ST_FINISH: begin
        if (status_i.slot_free) begin
          cmd.finish = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign cmd_o     = cmd;
  assign k_o       = k_q;
  assign rd_addr_o = cnt_q;

  // The walk never starts with no entries to update.
  `KTMP_ASSERT(a_run_k, clk_i, rst_ni, (state_q == ST_RUN) |-> (k_q != '0), "walk with zero limit")
  // The walk ends after the k-th entry read.
  `KTMP_ASSERT(a_run_end, clk_i, rst_ni, (state_q == ST_RUN) && run_end |=> (state_q == ST_DRAIN), "walk overran")
  // A finished sequence returns to accepting input.
  `KTMP_ASSERT(a_finish_idle, clk_i, rst_ni, cmd.finish |=> in_ready_o, "not ready after result")

endmodule

`default_nettype wire

// File: hdl/k_transaction_max_profit.sv
// Top level of the k-transaction maximum profit block.
//
// Prices arrive on the slave stream, one per transfer: tdata[15:0] is the
// price and tlast marks the final day of a sequence. After the final day
// one transfer leaves on the master stream with the profit in tdata[30:0].
// The transaction limit k is written over the cfg channel while the block
// is idle; values above MAX_TRANS are treated as MAX_TRANS.
// A price that is not a final day is taken in the idle state; unless k is
// zero, the walk then reads one buy/sell entry pair per cycle from the entry
// memory's single read port and the drain state writes back the last pair.
// A final day then passes to the finish state, which loads the result
// register once the output register is free.
// A finished result waits in its output register while the next sequence
// is taken in; only a second result stalls the block until the receiver
// takes the first. Reset clears all entries at once through valid bits,
// sets k to 2 and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module k_transaction_max_profit #(
  parameter int unsigned MAX_TRANS = ktmp_pkg::MAX_TRANS_DEF,
  parameter int unsigned MAX_DAYS  = ktmp_pkg::MAX_DAYS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration write channel: transaction limit
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic [ktmp_pkg::CFG_W-1:0]   cfg_data_i,
  // Price stream
  input  wire logic                         s_axis_tvalid_i,
  output      logic                         s_axis_tready_o,
  input  wire logic [ktmp_pkg::PRICE_W-1:0] s_axis_tdata_i,   // [15:0] price
  input  wire logic                         s_axis_tlast_i,
  // Profit stream
  output      logic                         m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  output      logic [ktmp_pkg::OUT_W-1:0]   m_axis_tdata_o    // [30:0] profit, [31] zero
);
  import ktmp_pkg::*;

  localparam int unsigned KW = $clog2(MAX_TRANS + 1);
  localparam int unsigned AW = (MAX_TRANS > 1) ? $clog2(MAX_TRANS) : 1;

  cmd_t                cmd;
  status_t             status;
  logic [KW-1:0]       k;
  logic [AW-1:0]       rd_addr;
  logic [PROFIT_W-1:0] profit;

  ktmp_ctrl #(
    .MAX_TRANS (MAX_TRANS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_last_i   (s_axis_tlast_i),
    .cmd_o       (cmd),
    .status_i    (status),
    .k_o         (k),
    .rd_addr_o   (rd_addr)
  );

  ktmp_dpath #(
    .MAX_TRANS (MAX_TRANS),
    .MAX_DAYS  (MAX_DAYS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .k_i         (k),
    .rd_addr_i   (rd_addr),
    .price_i     (s_axis_tdata_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .profit_o    (profit)
  );

  assign m_axis_tdata_o = {{(OUT_W-PROFIT_W){1'b0}}, profit};

endmodule

`default_nettype wire
